// ===== hdl/fmcf_pkg.sv =====
// fmcf_pkg: shared types and codes for the first-match connection filter
// no dependencies; used by fmcf_datapath, fmcf_ctrl and the top level under hdl
`default_nettype none

package fmcf_pkg;

    localparam int MAX_RULES_DEF = 16;

    // opcodes of an input request
    localparam logic OP_CLASSIFY = 1'b0;
    localparam logic OP_WRITE    = 1'b1;

    // rule and default actions, also the decision codes of a result
    localparam logic [1:0] ACT_ALLOW    = 2'd0;
    localparam logic [1:0] ACT_BLOCK    = 2'd1;
    localparam logic [1:0] ACT_REDIRECT = 2'd2;
    localparam logic [1:0] DEC_NOPOLICY = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_POLICY_PRESENT  = 3'd0;
    localparam logic [2:0] REG_FALLBACK_ACTION = 3'd1;
    localparam logic [2:0] REG_SVC_PORT        = 3'd2;
    localparam logic [2:0] REG_SVC_IP          = 3'd3;
    localparam logic [2:0] REG_RELAY_IP        = 3'd4;
    localparam logic [2:0] REG_RELAY_PORT      = 3'd5;
    localparam logic [2:0] REG_SVC_ROUTE_PORT  = 3'd6;
    localparam logic [2:0] REG_RULE_COUNT      = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // how a classify request is resolved
    typedef enum logic [1:0] {
        CLS_NOPOLICY,
        CLS_CONTAINER,
        CLS_RULE
    } cls_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [31:0] mask;
        logic [15:0] port;
        logic        any_protocol;
        logic [7:0]  protocol;
        logic [1:0]  action;
    } rule_t;

    typedef struct packed {
        logic accept;   // request taken this cycle
        logic fetch;    // first table read
        logic advance;  // next table read
        logic hit;      // capture action of matching rule
        logic load;     // load result register
    } cmd_t;

    typedef struct packed {
        logic classify; // pending request is a classify
        logic early;    // resolved without a table scan
        logic hit;      // rule on the read port matches
        logic last;     // rule on the read port is the last in use
    } sts_t;

endpackage

`default_nettype wire

// ===== hdl/fmcf_ram.sv =====
// fmcf_ram: generic single write, single read RAM with registered read data
// no dependencies
`default_nettype none

module fmcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/fmcf_datapath.sv =====
// fmcf_datapath: configuration registers, rule table, matcher and result register
// depends on fmcf_pkg and fmcf_ram
`default_nettype none

module fmcf_datapath #(
    parameter int MAX_RULES = fmcf_pkg::MAX_RULES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [31:0]       cfg_wdata,
    input  wire logic              opcode,
    input  wire logic [3:0]        rule_index,
    input  wire logic [31:0]       rule_ip,
    input  wire logic [31:0]       rule_mask,
    input  wire logic [15:0]       rule_port,
    input  wire logic [7:0]        rule_protocol,
    input  wire logic              rule_any_protocol,
    input  wire logic [1:0]        rule_action,
    input  wire logic [31:0]       dst_ip,
    input  wire logic [15:0]       dest_port,
    input  wire logic [7:0]        protocol,
    input  wire fmcf_pkg::cmd_t    cmd,
    output fmcf_pkg::sts_t         sts,
    output logic                   permit,
    output logic [1:0]             decision,
    output logic                   rewritten,
    output logic [31:0]            new_ip,
    output logic [15:0]            new_port
);

    localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CW = $clog2(MAX_RULES + 1);
    localparam logic [CW-1:0] N_MAX = CW'(MAX_RULES);

    // configuration
    logic        policy_present_reg;
    logic [1:0]  fallback_action_reg;
    logic [15:0] svc_port_reg;
    logic [31:0] svc_ip_reg;
    logic [31:0] relay_ip_reg;
    logic [15:0] relay_port_reg;
    logic [15:0] svc_route_port_reg;
    logic [4:0]  rule_count_reg;

    // request context
    logic [31:0]      ip_reg;
    logic [15:0]      port_reg;
    logic [7:0]       proto_reg;
    fmcf_pkg::cls_t   cls_reg;
    fmcf_pkg::cls_t   cls_next;
    logic [1:0]       act_reg;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_next;

    logic [CW-1:0]    n_rules;
    logic [31:0]      slot_wide;
    logic             slot_ok;
    logic             ram_we;
    fmcf_pkg::rule_t  wr_rule;
    fmcf_pkg::rule_t  rd_rule;
    logic [$bits(fmcf_pkg::rule_t)-1:0] rd_data;
    logic             container_hit;

    logic        permit_next;
    logic [1:0]  decision_next;
    logic        rewritten_next;
    logic [31:0] new_ip_next;
    logic [15:0] new_port_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_present_reg  <= 1'b0;
            fallback_action_reg <= 2'd0;
            svc_port_reg        <= 16'd0;
            svc_ip_reg          <= 32'd0;
            relay_ip_reg        <= 32'd0;
            relay_port_reg      <= 16'd0;
            svc_route_port_reg  <= 16'd0;
            rule_count_reg      <= 5'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fmcf_pkg::REG_POLICY_PRESENT:  policy_present_reg  <= cfg_wdata[0];
                fmcf_pkg::REG_FALLBACK_ACTION: fallback_action_reg <= cfg_wdata[1:0];
                fmcf_pkg::REG_SVC_PORT:        svc_port_reg        <= cfg_wdata[15:0];
                fmcf_pkg::REG_SVC_IP:          svc_ip_reg          <= cfg_wdata;
                fmcf_pkg::REG_RELAY_IP:        relay_ip_reg        <= cfg_wdata;
                fmcf_pkg::REG_RELAY_PORT:      relay_port_reg      <= cfg_wdata[15:0];
                fmcf_pkg::REG_SVC_ROUTE_PORT:  svc_route_port_reg  <= cfg_wdata[15:0];
                fmcf_pkg::REG_RULE_COUNT:      rule_count_reg      <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // rules in use, saturated at table depth
    assign n_rules = ({27'd0, rule_count_reg} > 32'(MAX_RULES)) ? N_MAX
                   : CW'(rule_count_reg);

    // rule table write
    assign slot_wide = {28'd0, rule_index};
    assign slot_ok   = slot_wide < 32'(MAX_RULES);
    assign ram_we    = cmd.accept && (opcode == fmcf_pkg::OP_WRITE) && slot_ok;

    always_comb
    begin
        wr_rule.ip           = rule_ip;
        wr_rule.mask         = rule_mask;
        wr_rule.port         = rule_port;
        wr_rule.any_protocol = rule_any_protocol;
        wr_rule.protocol     = rule_protocol;
        wr_rule.action       = rule_action;
    end

    fmcf_ram #(
        .WIDTH ($bits(fmcf_pkg::rule_t)),
        .DEPTH (MAX_RULES),
        .AW    (AW)
    ) u_rules (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_wide[AW-1:0]),
        .wdata (wr_rule),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (rd_data)
    );

    assign rd_rule = fmcf_pkg::rule_t'(rd_data);

    // early resolution on the incoming request
    assign container_hit = (svc_port_reg != 16'd0) && (dest_port == svc_port_reg)
                         && (dst_ip == svc_ip_reg);

    always_comb
    begin
        if (!policy_present_reg)
        begin
            cls_next = fmcf_pkg::CLS_NOPOLICY;
        end
        else if (container_hit)
        begin
            cls_next = fmcf_pkg::CLS_CONTAINER;
        end
        else
        begin
            cls_next = fmcf_pkg::CLS_RULE;
        end
    end

    always_comb
    begin
        sts.classify = (opcode == fmcf_pkg::OP_CLASSIFY);
        sts.early    = !policy_present_reg || container_hit || (n_rules == '0);
        sts.hit      = ((ip_reg & rd_rule.mask) == (rd_rule.ip & rd_rule.mask))
                    && ((rd_rule.port == 16'd0) || (rd_rule.port == port_reg))
                    && (rd_rule.any_protocol || (rd_rule.protocol == proto_reg));
        sts.last     = (cnt_reg == n_rules);
    end

    // read address counter
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.accept)
        begin
            cnt_next = '0;
        end
        else if (cmd.fetch || cmd.advance)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ip_reg    <= dst_ip;
            port_reg  <= dest_port;
            proto_reg <= protocol;
            cls_reg   <= cls_next;
            act_reg   <= fallback_action_reg;
        end
        else if (cmd.hit)
        begin
            act_reg <= rd_rule.action;
        end
    end

    // result
    always_comb
    begin
        permit_next    = 1'b1;
        decision_next  = fmcf_pkg::ACT_ALLOW;
        rewritten_next = 1'b0;
        new_ip_next    = ip_reg;
        new_port_next  = port_reg;
        case (cls_reg)
            fmcf_pkg::CLS_NOPOLICY:
            begin
                decision_next = fmcf_pkg::DEC_NOPOLICY;
            end
            fmcf_pkg::CLS_CONTAINER:
            begin
                decision_next = fmcf_pkg::ACT_REDIRECT;
                if (svc_route_port_reg != 16'd0)
                begin
                    rewritten_next = 1'b1;
                    new_ip_next    = relay_ip_reg;
                    new_port_next  = svc_route_port_reg;
                end
            end
            default:
            begin
                case (act_reg)
                    fmcf_pkg::ACT_BLOCK:
                    begin
                        permit_next   = 1'b0;
                        decision_next = fmcf_pkg::ACT_BLOCK;
                    end
                    fmcf_pkg::ACT_REDIRECT:
                    begin
                        decision_next = fmcf_pkg::ACT_REDIRECT;
                        if (relay_port_reg != 16'd0)
                        begin
                            rewritten_next = 1'b1;
                            new_ip_next    = relay_ip_reg;
                            new_port_next  = relay_port_reg;
                        end
                    end
                    // unused action code behaves as allow
                    default: ;
                endcase
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            permit    <= permit_next;
            decision  <= decision_next;
            rewritten <= rewritten_next;
            new_ip    <= new_ip_next;
            new_port  <= new_port_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/fmcf_ctrl.sv =====
// fmcf_ctrl: request sequencer for the connection filter and result valid flag
// depends on fmcf_pkg
`default_nettype none

module fmcf_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire fmcf_pkg::sts_t sts,
    output fmcf_pkg::cmd_t      cmd
);

    fmcf_pkg::state_t state_reg;
    fmcf_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;
    logic             scan_done;

    assign out_free  = !out_valid_reg || out_ready;
    assign scan_done = sts.hit || sts.last;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fmcf_pkg::ST_IDLE:
            begin
                if (in_valid && sts.classify)
                begin
                    state_next = sts.early ? fmcf_pkg::ST_FINISH : fmcf_pkg::ST_FETCH;
                end
            end
            fmcf_pkg::ST_FETCH:
            begin
                state_next = fmcf_pkg::ST_SCAN;
            end
            fmcf_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = fmcf_pkg::ST_FINISH;
                end
            end
            fmcf_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = fmcf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fmcf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd.accept  = 1'b0;
        cmd.fetch   = 1'b0;
        cmd.advance = 1'b0;
        cmd.hit     = 1'b0;
        cmd.load    = 1'b0;
        unique case (state_reg)
            fmcf_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            fmcf_pkg::ST_FETCH:
            begin
                cmd.fetch = 1'b1;
            end
            fmcf_pkg::ST_SCAN:
            begin
                cmd.hit     = sts.hit;
                cmd.advance = !scan_done;
            end
            fmcf_pkg::ST_FINISH:
            begin
                cmd.load = out_free;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fmcf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== hdl/first_match_connect_filter_top.sv =====
// first_match_connect_filter_top: first-match connection classifier, top level
// depends on fmcf_pkg, fmcf_ctrl, fmcf_datapath (and fmcf_ram below it)
//
//   channel  handshake            payload
//   -------  -------------------  ------------------------------------------
//   cfg      cfg_we               cfg_index, cfg_wdata
//   in       in_valid / in_ready  opcode, rule_*, dst_ip, dest_port, protocol
//   out      out_valid/out_ready  permit, decision, rewritten, new_ip, new_port
//
// a rule write gives no result; a classify resolved without the table (no policy,
// container hit, no rules) goes from idle to finish, else through fetch and a scan
// of the rules in order up to the first match or the last rule in use
// the next request is taken while a result waits; a classify finishing behind an
// untaken result stalls until it leaves
// reset clears configuration and control; the rule table is not cleared
`default_nettype none

module first_match_connect_filter_top #(
    parameter int MAX_RULES = fmcf_pkg::MAX_RULES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        opcode,
    input  wire logic [3:0]  rule_index,
    input  wire logic [31:0] rule_ip,
    input  wire logic [31:0] rule_mask,
    input  wire logic [15:0] rule_port,
    input  wire logic [7:0]  rule_protocol,
    input  wire logic        rule_any_protocol,
    input  wire logic [1:0]  rule_action,
    input  wire logic [31:0] dst_ip,
    input  wire logic [15:0] dest_port,
    input  wire logic [7:0]  protocol,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             permit,
    output logic [1:0]       decision,
    output logic             rewritten,
    output logic [31:0]      new_ip,
    output logic [15:0]      new_port
);

    fmcf_pkg::cmd_t cmd;
    fmcf_pkg::sts_t sts;

    fmcf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    fmcf_datapath #(
        .MAX_RULES (MAX_RULES)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .opcode            (opcode),
        .rule_index        (rule_index),
        .rule_ip           (rule_ip),
        .rule_mask         (rule_mask),
        .rule_port         (rule_port),
        .rule_protocol     (rule_protocol),
        .rule_any_protocol (rule_any_protocol),
        .rule_action       (rule_action),
        .dst_ip            (dst_ip),
        .dest_port         (dest_port),
        .protocol          (protocol),
        .cmd               (cmd),
        .sts               (sts),
        .permit            (permit),
        .decision          (decision),
        .rewritten         (rewritten),
        .new_ip            (new_ip),
        .new_port          (new_port)
    );

endmodule

`default_nettype wire
